@@ hdl/pli_pkg.sv @@
// Shared types and constants for the piecewise linear interpolator.
package pli_pkg;

    localparam int MAX_NODES = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = 5;
    localparam int DATA_W    = 16;
    localparam int DIV_STEPS = 32;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Request kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_ABS,
        S_DIV,
        S_SUM,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic             ram_we;
        logic [IDX_W-1:0] ram_addr;
        logic             take_query;
        logic             shift;
        logic             capture;
        logic             mul;
        logic             abs_init;
        logic             div_step;
        logic             sum;
        logic             set_miss;
        logic             out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic width_zero;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hdl/pli_ram.sv @@
// Generic single-port RAM with registered read.
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and read-first registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/pli_dp.sv @@
// Datapath: breakpoint store, interval test, multiply, restoring divide, saturation.
module pli_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pli_pkg::t_dp_cmd              i_cmd,
    output pli_pkg::t_dp_stat             o_stat,
    input  logic signed [pli_pkg::DATA_W-1:0] i_x_value,
    input  logic signed [pli_pkg::DATA_W-1:0] i_y_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [pli_pkg::DATA_W-1:0] o_interp_value,
    output logic                          o_in_range
);
    import pli_pkg::*;

    logic [2*DATA_W-1:0]        w_rdata;
    logic signed [DATA_W-1:0]   w_cur_x;
    logic signed [DATA_W-1:0]   w_cur_y;

    logic signed [DATA_W-1:0]   r_xq;
    logic signed [DATA_W-1:0]   r_prev_x;
    logic signed [DATA_W-1:0]   r_prev_y;
    logic signed [DATA_W-1:0]   r_x1;
    logic signed [DATA_W-1:0]   r_y1;
    logic signed [2*DATA_W+1:0] r_prod;
    logic [DATA_W-1:0]          r_width;
    logic [2*DATA_W-1:0]        r_dvd;
    logic [DATA_W-1:0]          r_rem;
    logic                       r_neg;
    logic signed [DATA_W-1:0]   r_res;
    logic                       r_hit;
    logic                       r_out_valid;
    logic signed [DATA_W-1:0]   r_out_res;
    logic                       r_out_hit;

    logic signed [DATA_W:0]     w_dy;
    logic signed [DATA_W:0]     w_dxq;
    logic signed [DATA_W:0]     w_dx;
    logic signed [2*DATA_W+1:0] w_prod_mag;
    logic [DATA_W:0]            w_rem_sh;
    logic [DATA_W:0]            w_rem_sub;
    logic                       w_ge;
    logic signed [DATA_W+1:0]   w_q;
    logic signed [DATA_W+2:0]   w_sum;
    logic signed [DATA_W-1:0]   w_sat;

    // Breakpoint store: x in the upper half, y in the lower
    pli_ram #(
        .WIDTH (2*DATA_W),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_addr  (i_cmd.ram_addr),
        .i_wdata ({i_x_value, i_y_value}),
        .o_rdata (w_rdata)
    );

    assign w_cur_x = w_rdata[2*DATA_W-1:DATA_W];
    assign w_cur_y = w_rdata[DATA_W-1:0];

    // Interval test against the entry just read
    assign o_stat.hit        = (r_prev_x <= r_xq) && (r_xq <= w_cur_x);
    assign o_stat.width_zero = (r_width == '0);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // Differences for the multiply
    assign w_dy  = {r_y1[DATA_W-1], r_y1} - {r_prev_y[DATA_W-1], r_prev_y};
    assign w_dxq = {r_xq[DATA_W-1], r_xq} - {r_prev_x[DATA_W-1], r_prev_x};
    assign w_dx  = {r_x1[DATA_W-1], r_x1} - {r_prev_x[DATA_W-1], r_prev_x};

    assign w_prod_mag = r_prod[2*DATA_W+1] ? -r_prod : r_prod;

    // One restoring divide step
    assign w_rem_sh  = {r_rem, r_dvd[2*DATA_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_width});
    assign w_rem_sub = w_rem_sh - {1'b0, r_width};

    // Signed quotient, add to y0, clamp to 16 bits
    assign w_q   = r_neg ? -$signed({1'b0, r_dvd[DATA_W:0]}) : $signed({1'b0, r_dvd[DATA_W:0]});
    assign w_sum = {{3{r_prev_y[DATA_W-1]}}, r_prev_y} + {w_q[DATA_W+1], w_q};

    always_comb begin
        if (w_sum > 19'sd32767) begin
            w_sat = 16'sh7FFF;
        end else if (w_sum < -19'sd32768) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = w_sum[DATA_W-1:0];
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_query) begin
            r_xq <= i_x_value;
        end
        if (i_cmd.shift) begin
            r_prev_x <= w_cur_x;
            r_prev_y <= w_cur_y;
        end
        if (i_cmd.capture) begin
            r_x1 <= w_cur_x;
            r_y1 <= w_cur_y;
        end
        if (i_cmd.mul) begin
            r_prod  <= w_dy * w_dxq;
            r_width <= w_dx[DATA_W-1:0];
        end
        if (i_cmd.abs_init) begin
            r_dvd <= w_prod_mag[2*DATA_W-1:0];
            r_neg <= r_prod[2*DATA_W+1];
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub[DATA_W-1:0] : w_rem_sh[DATA_W-1:0];
            r_dvd <= {r_dvd[2*DATA_W-2:0], w_ge};
        end
        if (i_cmd.sum) begin
            r_res <= w_sat;
            r_hit <= 1'b1;
        end
        if (i_cmd.set_miss) begin
            r_res <= '0;
            r_hit <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_res <= r_res;
            r_out_hit <= r_hit;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_interp_value = r_out_res;
    assign o_in_range     = r_out_hit;

endmodule

@@ hdl/pli_ctrl.sv @@
// Controller: request sequencing, breakpoint scan, divide step count, node count register.
module pli_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_kind,
    input  logic [pli_pkg::IDX_W-1:0] i_node_index,
    input  logic                      i_cfg_wr_en,
    input  logic [pli_pkg::CNT_W-1:0] i_cfg_wr_data,
    input  pli_pkg::t_dp_stat         i_stat,
    output pli_pkg::t_dp_cmd          o_cmd
);
    import pli_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_node_count;
    logic [IDX_W-1:0]  r_idx;
    logic [STEP_W-1:0] r_step;

    logic [CNT_W-1:0]  w_cnt;
    logic              w_few;
    logic              w_last;
    logic              w_found;

    // Counts above the table depth use the whole table
    assign w_cnt   = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;
    assign w_few   = (w_cnt < CNT_W'(2));
    assign w_last  = ({1'b0, r_idx} == (w_cnt - CNT_W'(1)));
    assign w_found = (r_idx != '0) && i_stat.hit;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= CNT_W'(MAX_NODES);
            r_idx        <= '0;
            r_step       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_node_count <= i_cfg_wr_data;
            end
            if (r_state == S_IDLE) begin
                r_idx <= '0;
            end else if (r_state == S_SCAN) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (r_state == S_ABS) begin
                r_step <= '0;
            end else if (r_state == S_DIV) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_kind == KIND_QUERY)) begin
                    n_state = w_few ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_found) begin
                    n_state = S_MUL;
                end else if (w_last) begin
                    n_state = S_DONE;
                end
            end
            S_MUL:  n_state = S_ABS;
            S_ABS:  n_state = i_stat.width_zero ? S_SUM : S_DIV;
            S_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:  n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.ram_we     = i_in_valid && (i_kind == KIND_LOAD);
                o_cmd.ram_addr   = (i_kind == KIND_LOAD) ? i_node_index : '0;
                o_cmd.take_query = i_in_valid && (i_kind == KIND_QUERY);
                o_cmd.set_miss   = i_in_valid && (i_kind == KIND_QUERY) && w_few;
            end
            S_SCAN: begin
                // prefetch the following entry while testing this one
                o_cmd.ram_addr = r_idx + IDX_W'(1);
                o_cmd.capture  = w_found;
                o_cmd.shift    = !w_found;
                o_cmd.set_miss = !w_found && w_last;
            end
            S_MUL:  o_cmd.mul      = 1'b1;
            S_ABS:  o_cmd.abs_init = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_SUM:  o_cmd.sum      = 1'b1;
            S_DONE: o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ hdl/piecewise_linear_interp.sv @@
// Piecewise linear interpolator over a 16-entry breakpoint table in signed Q7.8.
//
// Input channel (i_in_valid / o_in_ready) carries one request: a load writes
// breakpoint i_node_index and gives no result; a query returns one result on
// the output channel (o_out_valid / i_out_ready) with the interpolated value
// and an in-range flag. i_cfg_wr_en writes the node count (reset 16).
// A query scans one breakpoint per cycle from the single-port table, then
// multiplies, takes the sign, runs 32 restoring divide steps, saturates and
// loads the output register once the receiver has taken any earlier result.
// The controller then returns to idle, where the next request is taken. A
// miss goes from the scan straight to the output load, and a node count below
// two skips the scan. A hit on a zero-width interval skips the divide. One
// query is in flight at a time. The result sits in an output register, so the
// next request is taken while it waits; a stalled receiver holds only a
// following query at its end.
// Reset (synchronous, active low) clears control state and the output valid;
// table contents are undefined until loaded.
module piecewise_linear_interp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_kind,
    input  logic [pli_pkg::IDX_W-1:0]         i_node_index,
    input  logic signed [pli_pkg::DATA_W-1:0] i_x_value,
    input  logic signed [pli_pkg::DATA_W-1:0] i_y_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [pli_pkg::DATA_W-1:0] o_interp_value,
    output logic                              o_in_range,
    input  logic                              i_cfg_wr_en,
    input  logic [pli_pkg::CNT_W-1:0]         i_cfg_wr_data
);
    import pli_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pli_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_node_index  (i_node_index),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    pli_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_x_value      (i_x_value),
        .i_y_value      (i_y_value),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_interp_value (o_interp_value),
        .o_in_range     (o_in_range)
    );

    // Table writes only happen while requests are being taken
    a_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ram_we |-> o_in_ready)
        else $error("table write outside idle");

    // A result is never pushed into an occupied, stalled output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result overwrote a pending result");

    // A taken query keeps the input closed on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_kind == KIND_QUERY)) |=> !o_in_ready)
        else $error("input reopened straight after a query");

    // A load request never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_kind == KIND_LOAD) && !o_out_valid)
        |=> !o_out_valid)
        else $error("load request produced a result");

endmodule
